// ===== hdl/ppfc_pkg.sv =====
package ppfc_pkg;

	// input function codes
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// result kinds
	localparam logic KIND_CLASS = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// frame field values
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// byte positions (index of the byte, from 0)
	localparam logic [6:0] POS_MAX       = 7'd127;
	localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
	localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
	localparam logic [6:0] POS_IHL       = 7'd14;
	localparam logic [6:0] POS_PROTO     = 7'd23;
	localparam logic [6:0] POS_FLAG_MIN  = 7'd15;
	localparam logic [7:0] POS_FLAG_BASE = 8'd27;
	// last position of the shortest frame that counts at each level
	localparam logic [6:0] POS_ETH_MIN   = 7'd13;
	localparam logic [6:0] POS_IP_MIN    = 7'd33;
	localparam logic [7:0] POS_TCP_BASE  = 8'd33;

	// TCP flag bits
	localparam int unsigned FLAG_FIN = 0;
	localparam int unsigned FLAG_SYN = 1;
	localparam int unsigned FLAG_RST = 2;
	localparam int unsigned FLAG_ACK = 4;

	// counter indexes
	localparam int unsigned IDX_SYN = 0;
	localparam int unsigned IDX_ACK = 1;
	localparam int unsigned IDX_FIN = 2;
	localparam int unsigned IDX_RST = 3;
	localparam int unsigned IDX_UDP = 4;
	localparam int unsigned IDX_TCP = 5;
	localparam int unsigned IDX_IP  = 6;
	localparam int unsigned IDX_ARP = 7;
	localparam int unsigned NUM_COUNTERS = 8;

	// queue between front and back
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_BITS = 1;
	localparam int unsigned QCNT_BITS = 2;

	typedef struct packed {
		logic       is_read;
		logic [7:0] mask;
		logic [2:0] idx;
	} entry_t;

endpackage

// ===== hdl/ppfc_front.sv =====
module ppfc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  logic [7:0]       pkt_byte,
	input  logic             last_byte,
	input  logic [2:0]       counter_index,
	input  logic             q_full,
	output logic             push,
	output ppfc_pkg::entry_t push_entry
);

	logic [6:0]  pos_q;
	logic [15:0] etype_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [7:0]  flags_q;

	logic [15:0] etype_nx;
	logic [3:0]  hw_nx;
	logic [7:0]  proto_nx;
	logic [7:0]  flags_nx;
	logic [7:0]  flag_pos;
	logic [7:0]  tcp_min;
	logic [7:0]  class_mask;
	logic        acc;
	logic        acc_byte;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign acc_byte = acc && (func == ppfc_pkg::FUNC_BYTE);
	assign flag_pos = ppfc_pkg::POS_FLAG_BASE + {2'b00, hw_q, 2'b00};

	// capture header fields, including the byte now on the port
	always_comb begin
		etype_nx = etype_q;
		hw_nx    = hw_q;
		proto_nx = proto_q;
		flags_nx = flags_q;
		if (pos_q == ppfc_pkg::POS_ETYPE_HI) begin
			etype_nx = {pkt_byte, etype_q[7:0]};
		end else if (pos_q == ppfc_pkg::POS_ETYPE_LO) begin
			etype_nx = {etype_q[15:8], pkt_byte};
		end
		if (pos_q == ppfc_pkg::POS_IHL) begin
			hw_nx = pkt_byte[3:0];
		end
		if (pos_q == ppfc_pkg::POS_PROTO) begin
			proto_nx = pkt_byte;
		end
		if (pos_q >= ppfc_pkg::POS_FLAG_MIN && {1'b0, pos_q} == flag_pos) begin
			flags_nx = pkt_byte;
		end
	end

	assign tcp_min = ppfc_pkg::POS_TCP_BASE + {2'b00, hw_nx, 2'b00};

	// classify the frame as of its last byte
	always_comb begin
		class_mask = '0;
		if (pos_q >= ppfc_pkg::POS_ETH_MIN) begin
			if (etype_nx == ppfc_pkg::ETYPE_ARP) begin
				class_mask[ppfc_pkg::IDX_ARP] = 1'b1;
			end else if (etype_nx == ppfc_pkg::ETYPE_IPV4 && pos_q >= ppfc_pkg::POS_IP_MIN) begin
				class_mask[ppfc_pkg::IDX_IP] = 1'b1;
				if (proto_nx == ppfc_pkg::PROTO_TCP) begin
					class_mask[ppfc_pkg::IDX_TCP] = 1'b1;
					if ({1'b0, pos_q} >= tcp_min) begin
						class_mask[ppfc_pkg::IDX_SYN] = flags_nx[ppfc_pkg::FLAG_SYN];
						class_mask[ppfc_pkg::IDX_ACK] = flags_nx[ppfc_pkg::FLAG_ACK];
						class_mask[ppfc_pkg::IDX_FIN] = flags_nx[ppfc_pkg::FLAG_FIN];
						class_mask[ppfc_pkg::IDX_RST] = flags_nx[ppfc_pkg::FLAG_RST];
					end
				end else if (proto_nx == ppfc_pkg::PROTO_UDP) begin
					class_mask[ppfc_pkg::IDX_UDP] = 1'b1;
				end
			end
		end
	end

	assign push = acc && ((func == ppfc_pkg::FUNC_READ) || last_byte);

	always_comb begin
		push_entry.is_read = (func == ppfc_pkg::FUNC_READ);
		push_entry.idx     = counter_index;
		push_entry.mask    = (func == ppfc_pkg::FUNC_READ) ? 8'h00 : class_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			flags_q <= '0;
		end else if (acc_byte) begin
			etype_q <= etype_nx;
			hw_q    <= hw_nx;
			proto_q <= proto_nx;
			flags_q <= flags_nx;
			if (last_byte) begin
				pos_q <= '0;
			end else if (pos_q < ppfc_pkg::POS_MAX) begin
				pos_q <= pos_q + 7'd1;
			end
		end
	end

endmodule

// ===== hdl/ppfc_queue.sv =====
module ppfc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ppfc_pkg::entry_t push_entry,
	output logic             full,
	output logic             head_valid,
	input  logic             pop,
	output ppfc_pkg::entry_t head_entry
);

	ppfc_pkg::entry_t                   entries_q [ppfc_pkg::QDEPTH];
	logic [ppfc_pkg::QPTR_BITS-1:0]     wr_ptr_q;
	logic [ppfc_pkg::QPTR_BITS-1:0]     rd_ptr_q;
	logic [ppfc_pkg::QCNT_BITS-1:0]     count_q;

	assign full       = (count_q == ppfc_pkg::QCNT_BITS'(ppfc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/ppfc_back.sv =====
module ppfc_back #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  ppfc_pkg::entry_t        head_entry,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    result_kind,
	output logic [7:0]              counted_mask,
	output logic [COUNTER_BITS-1:0] counter_value
);

	logic [COUNTER_BITS-1:0] cnt_q [ppfc_pkg::NUM_COUNTERS];
	logic                    out_valid_q;
	logic                    kind_q;
	logic [7:0]              mask_q;
	logic [COUNTER_BITS-1:0] value_q;

	// advance when the output register is free or drains this cycle
	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign counted_mask  = mask_q;
	assign counter_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (pop && !head_entry.is_read) begin
			for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++) begin
				if (head_entry.mask[i]) begin
					cnt_q[i] <= cnt_q[i] + COUNTER_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_entry.is_read) begin
				kind_q  <= ppfc_pkg::KIND_READ;
				mask_q  <= 8'h00;
				value_q <= cnt_q[head_entry.idx];
			end else begin
				kind_q  <= ppfc_pkg::KIND_CLASS;
				mask_q  <= head_entry.mask;
				value_q <= '0;
			end
		end
	end

endmodule

// ===== hdl/packet_protocol_flag_counter.sv =====
// Ethernet / IPv4 / TCP protocol and flag statistics counter.
//
// Input channel (in_valid / in_stall): one item per accepted cycle. With
// func = 0 the item is one frame byte in wire order, last_byte marking the
// end of the frame; with func = 1 the item reads counter counter_index.
// Output channel (out_valid / out_stall): one result per frame (on its last
// byte) and one per read; non-last bytes give no result.
// The front stage captures header bytes as they pass and classifies the frame
// on its last byte; a two-entry queue carries classifications and reads to
// the back stage, which bumps the eight counters and fills the output
// register. Throughput is one item per cycle while in_stall stays low.
// A result passes the queue register and then the output register before
// out_valid rises. When out_stall is held the output register holds its
// result, the queue fills, and in_stall rises once both queue entries are
// taken. Reset clears all counters, the frame state and the queue; no item
// is lost or repeated across stalls on either side.
module packet_protocol_flag_counter #(
	parameter int unsigned COUNTER_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic [7:0]              pkt_byte,
	input  logic                    last_byte,
	input  logic [2:0]              counter_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    result_kind,
	output logic [7:0]              counted_mask,
	output logic [COUNTER_BITS-1:0] counter_value
);

	logic             q_full;
	logic             push;
	ppfc_pkg::entry_t push_entry;
	logic             head_valid;
	logic             pop;
	ppfc_pkg::entry_t head_entry;

	// capture header fields and classify each frame
	ppfc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.pkt_byte      (pkt_byte),
		.last_byte     (last_byte),
		.counter_index (counter_index),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	// decouple front from back so each side stalls on its own
	ppfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_entry (head_entry)
	);

	// update counters in order, so a read sees every earlier frame
	ppfc_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.counted_mask  (counted_mask),
		.counter_value (counter_value)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int unsigned CNT_W      = 64;
	// receiver hold-off during the back-pressure phase, in cycles
	localparam int unsigned HOLD_LEN   = 120;
	// cycles with no handshake on either side before the run is declared hung
	localparam int unsigned QUIET_MAX  = 2000;
	// wait well past the latency before the verdict
	localparam int unsigned DRAIN_TAIL = 20;
	// lower bounds per random phase
	localparam int unsigned PHASE_ITEMS  = 60;
	localparam int unsigned PHASE_FRAMES = 2;

	// one input item as offered on the link
	typedef struct {
		logic       f;
		logic [7:0] b;
		logic       lst;
		logic [2:0] sel;
	} link_item_t;

	// one result: classification mask or counter read data
	typedef struct {
		logic             kind;
		logic [7:0]       mask;
		logic [CNT_W-1:0] value;
	} verdict_t;

	logic             clk;
	logic             arst_n        = 1'b0;
	logic             in_valid      = 1'b0;
	logic             in_stall;
	logic             func          = ppfc_pkg::FUNC_BYTE;
	logic [7:0]       pkt_byte      = '0;
	logic             last_byte     = 1'b0;
	logic [2:0]       counter_index = '0;
	logic             out_valid;
	logic             out_stall     = 1'b0;
	logic             result_kind;
	logic [7:0]       counted_mask;
	logic [CNT_W-1:0] counter_value;

	packet_protocol_flag_counter #(
		.COUNTER_BITS(CNT_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.pkt_byte     (pkt_byte),
		.last_byte    (last_byte),
		.counter_index(counter_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.counted_mask (counted_mask),
		.counter_value(counter_value)
	);

	// Items waiting to go onto the link, and results owed by the block.
	link_item_t  frame_feed [$];
	verdict_t    due_verdicts [$];

	// Mirror of the block's frame state and statistics.
	logic [6:0]       fr_pos   = '0;
	logic [15:0]      fr_etype = '0;
	logic [3:0]       fr_ihl   = '0;
	logic [7:0]       fr_proto = '0;
	logic [7:0]       fr_flags = '0;
	logic [CNT_W-1:0] tally [ppfc_pkg::NUM_COUNTERS];

	// Idling controls, set per phase by the stimulus process.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_reqs      = 0;
	int unsigned holds_done     = 0;
	int unsigned hold_left      = 0;

	bit          in_taken    = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned fails        = 0;
	int unsigned items_queued  = 0;
	int unsigned frames_queued = 0;
	link_item_t  next_item;
	link_item_t  seen_item;
	verdict_t    want;

	initial begin
		for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++)
			tally[i] = '0;
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hold reset, then release it on a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Bump one counter and mark it in the classification mask.
	task automatic count_hit(input int unsigned idx, inout logic [7:0] m);
		tally[idx] = tally[idx] + 1'b1;
		m[idx] = 1'b1;
	endtask

	// Work out what one accepted item produces and update the mirrored state.
	// Frame bytes capture header fields at fixed positions; the last byte
	// classifies the frame. Reads return the current counter and leave the
	// frame state alone, whatever pkt_byte and last_byte carry.
	task automatic tally_item(input link_item_t it);
		verdict_t    v;
		int unsigned pos;
		int unsigned flag_pos;
		v.kind  = ppfc_pkg::KIND_CLASS;
		v.mask  = '0;
		v.value = '0;
		if (it.f == ppfc_pkg::FUNC_READ) begin
			v.kind  = ppfc_pkg::KIND_READ;
			v.value = tally[it.sel];
			due_verdicts.push_back(v);
			return;
		end
		pos = 32'(fr_pos);
		if (pos == ppfc_pkg::POS_ETYPE_HI)
			fr_etype[15:8] = it.b;
		else if (pos == ppfc_pkg::POS_ETYPE_LO)
			fr_etype[7:0] = it.b;
		if (pos == ppfc_pkg::POS_IHL)
			fr_ihl = it.b[3:0];
		if (pos == ppfc_pkg::POS_PROTO)
			fr_proto = it.b;
		// IHL is taken as-is, so a small IHL puts the flag byte inside the IP header
		flag_pos = ppfc_pkg::POS_FLAG_BASE + 4 * fr_ihl;
		if (pos >= ppfc_pkg::POS_FLAG_MIN && pos == flag_pos)
			fr_flags = it.b;
		if (!it.lst) begin
			// position saturates; longer frames look like 128-byte frames
			if (fr_pos < ppfc_pkg::POS_MAX)
				fr_pos = fr_pos + 1'b1;
			return;
		end
		if (pos >= ppfc_pkg::POS_ETH_MIN) begin
			if (fr_etype == ppfc_pkg::ETYPE_ARP) begin
				count_hit(ppfc_pkg::IDX_ARP, v.mask);
			end else if (fr_etype == ppfc_pkg::ETYPE_IPV4 && pos >= ppfc_pkg::POS_IP_MIN) begin
				count_hit(ppfc_pkg::IDX_IP, v.mask);
				if (fr_proto == ppfc_pkg::PROTO_TCP) begin
					count_hit(ppfc_pkg::IDX_TCP, v.mask);
					if (pos >= ppfc_pkg::POS_TCP_BASE + 4 * fr_ihl) begin
						if (fr_flags[ppfc_pkg::FLAG_SYN]) count_hit(ppfc_pkg::IDX_SYN, v.mask);
						if (fr_flags[ppfc_pkg::FLAG_ACK]) count_hit(ppfc_pkg::IDX_ACK, v.mask);
						if (fr_flags[ppfc_pkg::FLAG_FIN]) count_hit(ppfc_pkg::IDX_FIN, v.mask);
						if (fr_flags[ppfc_pkg::FLAG_RST]) count_hit(ppfc_pkg::IDX_RST, v.mask);
					end
				end else if (fr_proto == ppfc_pkg::PROTO_UDP) begin
					count_hit(ppfc_pkg::IDX_UDP, v.mask);
				end
			end
		end
		fr_pos = '0;
		due_verdicts.push_back(v);
	endtask

	// Queue a counter read; pkt_byte and last_byte carry junk on purpose.
	task automatic queue_read(input logic [2:0] sel);
		link_item_t it;
		it.f   = ppfc_pkg::FUNC_READ;
		it.b   = 8'($urandom);
		it.lst = 1'($urandom);
		it.sel = sel;
		frame_feed.push_back(it);
		items_queued++;
	endtask

	// Queue one frame of len bytes with the given header fields over random
	// filler. A read is slipped in before byte mid_read when it is in range.
	task automatic queue_frame(input logic [15:0] etype, input logic [3:0] ihl,
			input logic [7:0] proto, input logic [7:0] flags, input int len,
			input int mid_read);
		logic [7:0] body [$];
		int         flag_at;
		link_item_t it;
		flag_at = ppfc_pkg::POS_FLAG_BASE + 4 * ihl;
		for (int i = 0; i < len; i++)
			body.push_back(8'($urandom));
		if (len > ppfc_pkg::POS_ETYPE_HI) body[ppfc_pkg::POS_ETYPE_HI] = etype[15:8];
		if (len > ppfc_pkg::POS_ETYPE_LO) body[ppfc_pkg::POS_ETYPE_LO] = etype[7:0];
		if (len > ppfc_pkg::POS_IHL)
			body[ppfc_pkg::POS_IHL] = {body[ppfc_pkg::POS_IHL][7:4], ihl};
		if (len > ppfc_pkg::POS_PROTO)    body[ppfc_pkg::POS_PROTO]    = proto;
		if (len > flag_at)                body[flag_at]                = flags;
		for (int i = 0; i < len; i++) begin
			if (i == mid_read)
				queue_read(3'($urandom_range(ppfc_pkg::NUM_COUNTERS - 1)));
			it.f   = ppfc_pkg::FUNC_BYTE;
			it.b   = body[i];
			it.lst = (i == len - 1);
			it.sel = 3'($urandom);
			frame_feed.push_back(it);
			items_queued++;
		end
		frames_queued++;
	endtask

	// Mostly well-formed ARP / IPv4 / TCP / UDP frames with lengths clustered
	// on the count thresholds; the rest is near-miss and random EtherTypes,
	// runts and frames past the saturation point.
	task automatic queue_random_frame();
		int unsigned pick;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		int          tcp_len;
		int          len;
		int          mid;
		pick  = $urandom_range(99);
		etype = ppfc_pkg::ETYPE_IPV4;
		proto = 8'($urandom);
		ihl   = ($urandom_range(1) == 0) ? 4'd5 : 4'($urandom);
		if (pick < 30)
			proto = ppfc_pkg::PROTO_TCP;
		else if (pick < 50)
			proto = ppfc_pkg::PROTO_UDP;
		else if (pick < 65)
			etype = ppfc_pkg::ETYPE_ARP;
		else if (pick >= 85)
			etype = 16'($urandom);
		else if (pick >= 75)
			etype = (pick[0] ? ppfc_pkg::ETYPE_ARP : ppfc_pkg::ETYPE_IPV4)
				^ (16'd1 << $urandom_range(15));
		tcp_len = ppfc_pkg::POS_TCP_BASE + 1 + 4 * ihl;
		pick = $urandom_range(99);
		if (pick < 8) begin
			len = $urandom_range(ppfc_pkg::POS_ETH_MIN, 1);
		end else if (pick < 28) begin
			case ($urandom_range(4))
				0: len = ppfc_pkg::POS_ETH_MIN + 1;
				1: len = ppfc_pkg::POS_IP_MIN;
				2: len = ppfc_pkg::POS_IP_MIN + 1;
				3: len = tcp_len - 1;
				default: len = tcp_len;
			endcase
		end else if (pick < 95) begin
			len = $urandom_range(tcp_len + 8, ppfc_pkg::POS_ETH_MIN + 1);
		end else begin
			len = $urandom_range(200, ppfc_pkg::POS_MAX + 1);
		end
		mid = ($urandom_range(9) == 0) ? int'($urandom_range(len - 1)) : -1;
		queue_frame(etype, ihl, proto, 8'($urandom), len, mid);
		if ($urandom_range(99) < 40)
			queue_read(3'($urandom_range(ppfc_pkg::NUM_COUNTERS - 1)));
	endtask

	// Hold off new stimulus until the link is quiet and every result is in.
	task automatic drain();
		do
			@(posedge clk);
		while (frame_feed.size() != 0 || in_valid || due_verdicts.size() != 0);
	endtask

	// One random phase under the given idle and stall rates.
	task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct);
		int unsigned items_at_start;
		int unsigned frames_at_start;
		send_idle_pct   = send_pct;
		recv_stall_pct  = stall_pct;
		items_at_start  = items_queued;
		frames_at_start = frames_queued;
		while (items_queued - items_at_start < PHASE_ITEMS
				|| frames_queued - frames_at_start < PHASE_FRAMES)
			queue_random_frame();
		drain();
	endtask

	// Driver: advance to the next item on a falling edge once the current one
	// has been taken; hold the payload while stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (frame_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = frame_feed.pop_front();
				in_valid      <= 1'b1;
				func          <= next_item.f;
				pkt_byte      <= next_item.b;
				last_byte     <= next_item.lst;
				counter_index <= next_item.sel;
			end else begin
				// idle: scramble the payload so nothing leaks from it
				in_valid      <= 1'b0;
				func          <= 1'($urandom);
				pkt_byte      <= 8'($urandom);
				last_byte     <= 1'($urandom);
				counter_index <= 3'($urandom);
			end
		end
	end

	// Receiver: a requested hold-off stalls unbroken until it runs out,
	// otherwise stall at the phase rate.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_reqs != holds_done) begin
			out_stall <= 1'b1;
			hold_left  = HOLD_LEN - 1;
			holds_done = holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: on each rising edge check an accepted result against the oldest
	// owed one, predict for an accepted item, and watch for a hung link.
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (due_verdicts.size() == 0) begin
					$error("unexpected result: kind %0d mask %h value %h",
						result_kind, counted_mask, counter_value);
					fails++;
				end else begin
					want = due_verdicts.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
						fails++;
					end
					if (counted_mask !== want.mask) begin
						$error("counted_mask: expected %h, got %h", want.mask, counted_mask);
						fails++;
					end
					if (counter_value !== want.value) begin
						$error("counter_value: expected %h, got %h",
							want.value, counter_value);
						fails++;
					end
				end
			end
			if (in_taken) begin
				seen_item.f   = func;
				seen_item.b   = pkt_byte;
				seen_item.lst = last_byte;
				seen_item.sel = counter_index;
				tally_item(seen_item);
			end
			if (in_taken || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_MAX) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// Stimulus: directed frames, a back-pressure burst, then random phases.
	initial begin
		// counters straight out of reset
		for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++)
			queue_read(3'(i));
		// runts: one byte, and one byte short of an Ethernet header
		queue_frame(ppfc_pkg::ETYPE_ARP, 4'd5, ppfc_pkg::PROTO_TCP, 8'hFF, 1, -1);
		queue_frame(ppfc_pkg::ETYPE_ARP, 4'd5, ppfc_pkg::PROTO_TCP, 8'hFF,
			ppfc_pkg::POS_ETH_MIN, -1);
		// shortest ARP
		queue_frame(ppfc_pkg::ETYPE_ARP, 4'd5, ppfc_pkg::PROTO_TCP, 8'h00,
			ppfc_pkg::POS_ETH_MIN + 1, -1);
		// IPv4 one byte short, then shortest UDP
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd5, ppfc_pkg::PROTO_TCP, 8'hFF,
			ppfc_pkg::POS_IP_MIN, -1);
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd5, ppfc_pkg::PROTO_UDP, 8'hFF,
			ppfc_pkg::POS_IP_MIN + 1, -1);
		// TCP one byte short of the flags, then just long enough with a read inside
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd5, ppfc_pkg::PROTO_TCP, 8'hFF, 53, -1);
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd5, ppfc_pkg::PROTO_TCP, 8'h17, 54, 20);
		// small IHL: flag byte inside the IP header
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd0, ppfc_pkg::PROTO_TCP, 8'h12,
			ppfc_pkg::POS_IP_MIN + 1, -1);
		// largest IHL on a frame past the position saturation
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd15, ppfc_pkg::PROTO_TCP, 8'h05, 130, -1);
		// IPv4 with another protocol, and extreme EtherTypes
		queue_frame(ppfc_pkg::ETYPE_IPV4, 4'd5, 8'd1, 8'hFF, 34, -1);
		queue_frame(16'h0000, 4'd5, ppfc_pkg::PROTO_TCP, 8'hFF, 34, -1);
		queue_frame(16'hFFFF, 4'd5, ppfc_pkg::PROTO_UDP, 8'hFF, 34, -1);
		for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++)
			queue_read(3'(i));
		drain();

		// long receiver hold-off while short items keep coming, so the
		// result queue fills and the input stalls
		hold_reqs = hold_reqs + 1;
		for (int i = 0; i < 8; i++) begin
			if (i % 2)
				queue_read(3'($urandom_range(ppfc_pkg::NUM_COUNTERS - 1)));
			else
				queue_frame(ppfc_pkg::ETYPE_ARP, 4'd5, ppfc_pkg::PROTO_TCP, 8'h00,
					ppfc_pkg::POS_ETH_MIN + 1, -1);
		end
		drain();

		run_phase(0, 0);
		run_phase(74, 0);
		run_phase(0, 74);
		run_phase(12, 12);

		repeat (DRAIN_TAIL) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
